### rtl/ots_pkg.sv
// Shared constants, codes and control types for the overlap-add time stretcher.
// No dependencies; every other file but ots_ram imports this package.
package ots_pkg;

    localparam int DEF_MAX_SEGMENT = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int ACC_BITS        = 24;
    localparam int MIN_SEGMENT     = 4;
    localparam int POS_RESET       = 400;

    // configuration register file
    localparam int CFG_W      = 11;
    localparam int FADE_W     = 10;
    localparam int STEP_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHIFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP    = 3'd4;

    localparam logic [CFG_W-1:0]  SEG_RESET  = 11'd800;
    localparam logic [CFG_W-1:0]  ISH_RESET  = 11'd400;
    localparam logic [CFG_W-1:0]  OSH_RESET  = 11'd400;
    localparam logic [FADE_W-1:0] FADE_RESET = 10'd80;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd830;
    localparam logic [STEP_W-1:0] ONE_Q16    = 17'h10000;

    // item actions and result status
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam logic [ACT_W-1:0] ACT_PUSH    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PULL    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DRAIN   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd3;
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_GIVEN  = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSE = 2'd2;
    localparam logic [STAT_W-1:0] ST_TAIL   = 2'd3;

    // datapath commands
    typedef logic [4:0] cmd_t;
    localparam cmd_t CMD_NONE      = 5'd0;
    localparam cmd_t CMD_ACCEPT    = 5'd1;
    localparam cmd_t CMD_CLR_WR    = 5'd2;
    localparam cmd_t CMD_RST_END   = 5'd3;
    localparam cmd_t CMD_PUSH_WR   = 5'd4;
    localparam cmd_t CMD_REFUSE    = 5'd5;
    localparam cmd_t CMD_TAIL      = 5'd6;
    localparam cmd_t CMD_IDX_FILL  = 5'd7;
    localparam cmd_t CMD_IDX_ZERO  = 5'd8;
    localparam cmd_t CMD_ZF_WR     = 5'd9;
    localparam cmd_t CMD_CMB_RD    = 5'd10;
    localparam cmd_t CMD_CMB_MUL   = 5'd11;
    localparam cmd_t CMD_CMB_WR    = 5'd12;
    localparam cmd_t CMD_SHI_RD    = 5'd13;
    localparam cmd_t CMD_SHI_WR    = 5'd14;
    localparam cmd_t CMD_SHI_END   = 5'd15;
    localparam cmd_t CMD_PULL_RD   = 5'd16;
    localparam cmd_t CMD_PULL_GIVE = 5'd17;
    localparam cmd_t CMD_SHO_RD    = 5'd18;
    localparam cmd_t CMD_SHO_WR    = 5'd19;
    localparam cmd_t CMD_SHO_END   = 5'd20;
    localparam cmd_t CMD_DRAIN_END = 5'd21;
    localparam cmd_t CMD_DONE      = 5'd22;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             phase;
        logic             drain;
        logic             fill_hit;
        logic             emit_lt_fill;
        logic             emit_lt_seg;
        logic             emit_lt_osh;
        logic             idx_lt_seg;
        logic             idx_ish_lt_seg;
        logic             idx_lt_max;
        logic             out_free;
    } dp_stat_t;

endpackage

### rtl/ots_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ots_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/ots_datapath.sv
// Datapath: config registers, positions, segment and accumulator RAMs, fade
// weighting, result register. Depends on ots_pkg and ots_ram.
module ots_datapath import ots_pkg::*; #(
    parameter int MAX_SEGMENT = DEF_MAX_SEGMENT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output dp_stat_t               stat,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [ACT_W-1:0]       in_action,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STAT_W-1:0]      out_status,
    output logic [SAMPLE_BITS-1:0] out_sample
);

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_SEGMENT);
    localparam int LW    = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int PW    = STEP_W + LW;
    localparam int MW    = SB + 18;
    localparam int AD    = SB + 2;
    localparam int SUM_W = ((ACC_BITS > AD) ? ACC_BITS : AD) + 1;
    localparam int EW    = (ACC_BITS > SB) ? ACC_BITS : SB;

    localparam logic signed [SUM_W-1:0] AMAX =
        {{(SUM_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] AMIN =
        {{(SUM_W-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [EW-1:0] SMAX = {{(EW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN = {{(EW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic [CFG_W-1:0]  seg_cfg_reg, ish_cfg_reg, osh_cfg_reg;
    logic [FADE_W-1:0] fade_cfg_reg;
    logic [STEP_W-1:0] step_cfg_reg;

    logic [LW-1:0] fill_reg, emit_reg, idx_reg;
    logic          phase_reg, drain_reg;
    logic [ACT_W-1:0] act_reg;
    logic [SB-1:0]    smp_reg;
    logic [STAT_W-1:0] stat_reg, out_stat_reg;
    logic [SB-1:0]     val_reg, out_val_reg;
    logic              out_valid_reg;
    logic              src_reg;

    // combine pipeline registers
    logic                 w_one_reg, w_zero_reg, unity_reg;
    logic [PW-1:0]        prod_reg;
    logic signed [MW-1:0] t_reg;
    logic signed [SB-1:0] s_reg;

    // effective register values
    logic [LW-1:0] seg_raw, seg, ish_raw, ish, osh_raw, osh, fade_raw, fade, half;
    logic [STEP_W-1:0] step;

    always_comb
    begin
        seg_raw = LW'(seg_cfg_reg);
        if (seg_raw < LW'(MIN_SEGMENT))
            seg = LW'(MIN_SEGMENT);
        else if (seg_raw > LW'(MAX_SEGMENT))
            seg = LW'(MAX_SEGMENT);
        else
            seg = seg_raw;
        ish_raw = LW'(ish_cfg_reg);
        ish = (ish_raw == '0) ? LW'(1) : ((ish_raw > seg) ? seg : ish_raw);
        osh_raw = LW'(osh_cfg_reg);
        osh = (osh_raw == '0) ? LW'(1) : ((osh_raw > seg) ? seg : osh_raw);
        half = seg >> 1;
        fade_raw = LW'(fade_cfg_reg);
        fade = (fade_raw > half) ? half : fade_raw;
        step = (step_cfg_reg > ONE_Q16) ? ONE_Q16 : step_cfg_reg;
    end

    logic [LW-1:0] fc;
    logic [LW:0]   idx_ish, idx_osh;

    assign fc      = (fill_reg >= seg) ? seg - LW'(1) : fill_reg;
    assign idx_ish = {1'b0, idx_reg} + {1'b0, ish};
    assign idx_osh = {1'b0, idx_reg} + {1'b0, osh};

    always_comb
    begin
        stat.act            = act_reg;
        stat.phase          = phase_reg;
        stat.drain          = drain_reg;
        stat.fill_hit       = (fc == seg - LW'(1));
        stat.emit_lt_fill   = emit_reg < fill_reg;
        stat.emit_lt_seg    = emit_reg < seg;
        stat.emit_lt_osh    = emit_reg < osh;
        stat.idx_lt_seg     = idx_reg < seg;
        stat.idx_ish_lt_seg = idx_ish < {1'b0, seg};
        stat.idx_lt_max     = idx_reg < LW'(MAX_SEGMENT);
        stat.out_free       = !out_valid_reg || out_ready;
    end

    // RAM ports
    logic          st_we, st_re, ac_we, ac_re;
    logic [AW-1:0] st_waddr, st_raddr, ac_waddr, ac_raddr;
    logic [SB-1:0] st_wdata, st_rdata;
    logic [ACC_BITS-1:0] ac_wdata, ac_rdata, acc_sat;

    // fade weight for the current index
    logic          rise, fall, kz, kbig;
    logic [LW-1:0] m;
    logic [STEP_W-1:0] w;
    logic signed [MW-1:0] t_next, rnd;
    logic signed [AD-1:0] add_s;
    logic signed [SUM_W-1:0] sum;
    logic signed [EW-1:0] acc_e;
    logic [SB-1:0] give_val;

    always_comb
    begin
        rise = idx_reg < fade;
        fall = idx_reg >= seg - fade;
        m    = rise ? idx_reg : seg - LW'(1) - idx_reg;
        kz   = rise ? (idx_reg == fade - LW'(1)) : (idx_reg == seg - fade);
        kbig = rise ? (idx_reg == '0) : (idx_reg == seg - LW'(1));

        if (w_one_reg)
            w = ONE_Q16;
        else if (w_zero_reg)
            w = '0;
        else if (prod_reg > PW'(ONE_Q16))
            w = ONE_Q16;
        else
            w = prod_reg[STEP_W-1:0];
        t_next = $signed(st_rdata) * $signed({1'b0, w});

        rnd   = t_reg + $signed(MW'(32768));
        add_s = unity_reg ? AD'(s_reg) : rnd[MW-1:16];
        sum   = SUM_W'($signed(ac_rdata)) + SUM_W'(add_s);
        if (sum > AMAX)
            acc_sat = AMAX[ACC_BITS-1:0];
        else if (sum < AMIN)
            acc_sat = AMIN[ACC_BITS-1:0];
        else
            acc_sat = sum[ACC_BITS-1:0];

        acc_e = EW'($signed(ac_rdata));
        if (acc_e > SMAX)
            give_val = SMAX[SB-1:0];
        else if (acc_e < SMIN)
            give_val = SMIN[SB-1:0];
        else
            give_val = acc_e[SB-1:0];
    end

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = idx_reg[AW-1:0];
        st_wdata = '0;
        st_re    = 1'b0;
        st_raddr = idx_reg[AW-1:0];
        ac_we    = 1'b0;
        ac_waddr = idx_reg[AW-1:0];
        ac_wdata = '0;
        ac_re    = 1'b0;
        ac_raddr = idx_reg[AW-1:0];
        case (cmd)
            CMD_CLR_WR:
            begin
                st_we = 1'b1;
                ac_we = 1'b1;
            end
            CMD_PUSH_WR:
            begin
                st_we    = 1'b1;
                st_waddr = fc[AW-1:0];
                st_wdata = smp_reg;
            end
            CMD_ZF_WR:
            begin
                st_we = 1'b1;
            end
            CMD_CMB_RD:
            begin
                st_re = 1'b1;
                ac_re = 1'b1;
            end
            CMD_CMB_WR:
            begin
                ac_we    = 1'b1;
                ac_wdata = acc_sat;
            end
            CMD_SHI_RD:
            begin
                st_re    = 1'b1;
                st_raddr = idx_ish[AW-1:0];
            end
            CMD_SHI_WR:
            begin
                st_we    = 1'b1;
                st_wdata = st_rdata;
            end
            CMD_PULL_RD:
            begin
                ac_re    = 1'b1;
                ac_raddr = emit_reg[AW-1:0];
            end
            CMD_SHO_RD:
            begin
                ac_re    = 1'b1;
                ac_raddr = idx_osh[AW-1:0];
            end
            CMD_SHO_WR:
            begin
                ac_we    = 1'b1;
                ac_wdata = src_reg ? ac_rdata : '0;
            end
            default:
            begin
            end
        endcase
    end

    ots_ram #(.WIDTH(SB), .DEPTH(MAX_SEGMENT)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    ots_ram #(.WIDTH(ACC_BITS), .DEPTH(MAX_SEGMENT)) u_acc (
        .clk   (clk),
        .we    (ac_we),
        .waddr (ac_waddr),
        .wdata (ac_wdata),
        .re    (ac_re),
        .raddr (ac_raddr),
        .rdata (ac_rdata)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_cfg_reg  <= SEG_RESET;
            ish_cfg_reg  <= ISH_RESET;
            osh_cfg_reg  <= OSH_RESET;
            fade_cfg_reg <= FADE_RESET;
            step_cfg_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SEGMENT_LEN:  seg_cfg_reg  <= cfg_wdata[CFG_W-1:0];
                REG_INPUT_SHIFT:  ish_cfg_reg  <= cfg_wdata[CFG_W-1:0];
                REG_OUTPUT_SHIFT: osh_cfg_reg  <= cfg_wdata[CFG_W-1:0];
                REG_FADE_LEN:     fade_cfg_reg <= cfg_wdata[FADE_W-1:0];
                REG_FADE_STEP:    step_cfg_reg <= cfg_wdata[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= LW'(POS_RESET);
            emit_reg      <= LW'(POS_RESET);
            phase_reg     <= 1'b0;
            drain_reg     <= 1'b0;
            idx_reg       <= '0;
            act_reg       <= ACT_PUSH;
            stat_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_DONE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (cmd)
                CMD_ACCEPT:
                begin
                    act_reg  <= in_action;
                    stat_reg <= ST_OK;
                end
                CMD_CLR_WR, CMD_ZF_WR, CMD_CMB_WR, CMD_SHI_WR, CMD_SHO_WR:
                    idx_reg <= idx_reg + LW'(1);
                CMD_RST_END:
                begin
                    fill_reg  <= half;
                    emit_reg  <= half;
                    phase_reg <= 1'b0;
                    drain_reg <= 1'b0;
                end
                CMD_PUSH_WR:
                begin
                    fill_reg <= fc + LW'(1);
                    idx_reg  <= '0;
                end
                CMD_REFUSE: stat_reg <= ST_REFUSE;
                CMD_TAIL:   stat_reg <= ST_TAIL;
                CMD_IDX_FILL: idx_reg <= fill_reg;
                CMD_IDX_ZERO: idx_reg <= '0;
                CMD_SHI_END:
                begin
                    fill_reg  <= fill_reg - ish;
                    phase_reg <= 1'b1;
                end
                CMD_PULL_GIVE:
                begin
                    emit_reg <= emit_reg + LW'(1);
                    stat_reg <= ST_GIVEN;
                end
                CMD_SHO_END:
                begin
                    emit_reg  <= emit_reg - osh;
                    phase_reg <= 1'b0;
                end
                CMD_DRAIN_END:
                begin
                    phase_reg <= 1'b1;
                    drain_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_ACCEPT:
            begin
                smp_reg <= in_sample;
                val_reg <= '0;
            end
            CMD_CMB_RD:
            begin
                w_one_reg  <= !(rise || fall) || kz;
                w_zero_reg <= kbig;
                prod_reg   <= PW'(step) * PW'(m);
            end
            CMD_CMB_MUL:
            begin
                t_reg     <= t_next;
                unity_reg <= (w == ONE_Q16);
                s_reg     <= $signed(st_rdata);
            end
            CMD_SHO_RD: src_reg <= idx_osh < {1'b0, seg};
            CMD_PULL_GIVE: val_reg <= give_val;
            CMD_DONE:
            begin
                out_stat_reg <= stat_reg;
                out_val_reg  <= val_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_stat_reg;
    assign out_sample = out_val_reg;

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_DONE |=> out_valid_reg)
        else $error("result not presented after load");

    a_drain_phase: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> phase_reg)
        else $error("draining outside output phase");

    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_PUSH_WR |=> fill_reg <= seg)
        else $error("fill position past segment after push");

endmodule

### rtl/ots_controller.sv
// Controller FSM: sequences accept, push, pull, combine walk, shifts, drain,
// clearing pass and result hand-off. Depends on ots_pkg.
module ots_controller import ots_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    localparam logic [4:0] S_CLR_CHK   = 5'd0;
    localparam logic [4:0] S_CLR_WR    = 5'd1;
    localparam logic [4:0] S_RST_END   = 5'd2;
    localparam logic [4:0] S_IDLE      = 5'd3;
    localparam logic [4:0] S_DISP      = 5'd4;
    localparam logic [4:0] S_PUSH      = 5'd5;
    localparam logic [4:0] S_CMB_CHK   = 5'd6;
    localparam logic [4:0] S_CMB_RD    = 5'd7;
    localparam logic [4:0] S_CMB_MUL   = 5'd8;
    localparam logic [4:0] S_CMB_WR    = 5'd9;
    localparam logic [4:0] S_SHI_CHK   = 5'd10;
    localparam logic [4:0] S_SHI_RD    = 5'd11;
    localparam logic [4:0] S_SHI_WR    = 5'd12;
    localparam logic [4:0] S_SHI_END   = 5'd13;
    localparam logic [4:0] S_PULL_RD   = 5'd14;
    localparam logic [4:0] S_PULL_GIVE = 5'd15;
    localparam logic [4:0] S_PULL_CHK  = 5'd16;
    localparam logic [4:0] S_SHO_CHK   = 5'd17;
    localparam logic [4:0] S_SHO_RD    = 5'd18;
    localparam logic [4:0] S_SHO_WR    = 5'd19;
    localparam logic [4:0] S_SHO_END   = 5'd20;
    localparam logic [4:0] S_ZF_CHK    = 5'd21;
    localparam logic [4:0] S_ZF_WR     = 5'd22;
    localparam logic [4:0] S_DRAIN_END = 5'd23;
    localparam logic [4:0] S_DONE      = 5'd24;

    logic [4:0] state_reg, state_next;
    logic       boot_reg, boot_next;

    always_comb
    begin
        cmd        = CMD_NONE;
        state_next = state_reg;
        boot_next  = boot_reg;
        case (state_reg)
            S_CLR_CHK:
            begin
                if (stat.idx_lt_max)
                    state_next = S_CLR_WR;
                else
                begin
                    // the clearing pass after reset gives no result
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_RST_END;
                end
            end
            S_CLR_WR:
            begin
                cmd        = CMD_CLR_WR;
                state_next = S_CLR_CHK;
            end
            S_RST_END:
            begin
                cmd        = CMD_RST_END;
                state_next = S_DONE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.act)
                    ACT_PUSH:
                    begin
                        if (stat.phase || stat.drain)
                        begin
                            cmd        = CMD_REFUSE;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_PUSH;
                    end
                    ACT_PULL:
                    begin
                        if (stat.drain)
                        begin
                            if (stat.emit_lt_fill && stat.emit_lt_seg)
                                state_next = S_PULL_RD;
                            else
                            begin
                                cmd        = CMD_TAIL;
                                state_next = S_DONE;
                            end
                        end
                        else if (!stat.phase)
                        begin
                            cmd        = CMD_REFUSE;
                            state_next = S_DONE;
                        end
                        else if (stat.emit_lt_osh)
                            state_next = S_PULL_RD;
                        else
                        begin
                            cmd        = CMD_IDX_ZERO;
                            state_next = S_SHO_CHK;
                        end
                    end
                    ACT_DRAIN:
                    begin
                        if (stat.drain)
                        begin
                            cmd        = CMD_REFUSE;
                            state_next = S_DONE;
                        end
                        else if (!stat.phase)
                        begin
                            cmd        = CMD_IDX_FILL;
                            state_next = S_ZF_CHK;
                        end
                        else
                            state_next = S_DRAIN_END;
                    end
                    default:
                    begin
                        cmd        = CMD_IDX_ZERO;
                        state_next = S_CLR_CHK;
                    end
                endcase
            end
            S_PUSH:
            begin
                cmd        = CMD_PUSH_WR;
                state_next = stat.fill_hit ? S_CMB_CHK : S_DONE;
            end
            S_CMB_CHK:
            begin
                if (stat.idx_lt_seg)
                    state_next = S_CMB_RD;
                else if (stat.act == ACT_PUSH)
                begin
                    cmd        = CMD_IDX_ZERO;
                    state_next = S_SHI_CHK;
                end
                else
                    state_next = S_DRAIN_END;
            end
            S_CMB_RD:
            begin
                cmd        = CMD_CMB_RD;
                state_next = S_CMB_MUL;
            end
            S_CMB_MUL:
            begin
                cmd        = CMD_CMB_MUL;
                state_next = S_CMB_WR;
            end
            S_CMB_WR:
            begin
                cmd        = CMD_CMB_WR;
                state_next = S_CMB_CHK;
            end
            S_SHI_CHK:
            begin
                state_next = stat.idx_ish_lt_seg ? S_SHI_RD : S_SHI_END;
            end
            S_SHI_RD:
            begin
                cmd        = CMD_SHI_RD;
                state_next = S_SHI_WR;
            end
            S_SHI_WR:
            begin
                cmd        = CMD_SHI_WR;
                state_next = S_SHI_CHK;
            end
            S_SHI_END:
            begin
                cmd        = CMD_SHI_END;
                state_next = S_DONE;
            end
            S_PULL_RD:
            begin
                cmd        = CMD_PULL_RD;
                state_next = S_PULL_GIVE;
            end
            S_PULL_GIVE:
            begin
                cmd        = CMD_PULL_GIVE;
                state_next = S_PULL_CHK;
            end
            S_PULL_CHK:
            begin
                if (!stat.drain && !stat.emit_lt_osh)
                begin
                    cmd        = CMD_IDX_ZERO;
                    state_next = S_SHO_CHK;
                end
                else
                    state_next = S_DONE;
            end
            S_SHO_CHK:
            begin
                state_next = stat.idx_lt_seg ? S_SHO_RD : S_SHO_END;
            end
            S_SHO_RD:
            begin
                cmd        = CMD_SHO_RD;
                state_next = S_SHO_WR;
            end
            S_SHO_WR:
            begin
                cmd        = CMD_SHO_WR;
                state_next = S_SHO_CHK;
            end
            S_SHO_END:
            begin
                cmd        = CMD_SHO_END;
                state_next = S_DONE;
            end
            S_ZF_CHK:
            begin
                if (stat.idx_lt_seg)
                    state_next = S_ZF_WR;
                else
                begin
                    cmd        = CMD_IDX_ZERO;
                    state_next = S_CMB_CHK;
                end
            end
            S_ZF_WR:
            begin
                cmd        = CMD_ZF_WR;
                state_next = S_ZF_CHK;
            end
            S_DRAIN_END:
            begin
                cmd        = CMD_DRAIN_END;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_CHK;
            boot_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DISP)
        else $error("accepted item not dispatched");

    a_boot_once: assert property (@(posedge clk) disable iff (!rst_n)
        !boot_reg |=> !boot_reg)
        else $error("boot clearing pass re-armed");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_DONE |-> stat.out_free)
        else $error("result overwritten before taken");

endmodule

### rtl/overlap_add_time_stretch.sv
// Overlap-add time stretcher top level: stream ports, config port, and the
// controller/datapath pair. Depends on ots_pkg, ots_controller, ots_datapath.
//
// One item on the input stream carries an action (push, pull, drain, restart)
// and gets exactly one result item (status plus output sample). Items are handled
// one at a time by the controller; a finished result sits in an output register,
// and the next item is accepted while it waits. The push that fills a segment also
// runs the combine walk over every segment entry and then the input shift over the
// kept entries; a pull that ends the output window runs the accumulator shift over
// every segment entry; a drain in the input phase zero-fills the missing entries
// and then combines. All walks are bound by the single read and write port of each
// RAM. After reset, and on every restart, a clearing pass zeroes both RAMs; no item
// is accepted during it, while configuration writes are taken at any time.
module overlap_add_time_stretch import ots_pkg::*; #(
    parameter int MAX_SEGMENT = DEF_MAX_SEGMENT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [CFG_IDX_W-1:0]              cfg_addr,
    input  logic [CFG_DATA_W-1:0]             cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: sample, zero padded to whole bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // tuser: action
    input  logic [ACT_W-1:0]                  s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: out_sample, zero padded to whole bytes
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // tuser: status
    output logic [STAT_W-1:0]                 m_axis_tuser
);

    localparam int TD_W = ((SAMPLE_BITS + 7) / 8) * 8;

    cmd_t     cmd;
    dp_stat_t stat;
    logic [SAMPLE_BITS-1:0] out_sample;

    ots_controller u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ots_datapath #(
        .MAX_SEGMENT (MAX_SEGMENT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_action  (s_axis_tuser),
        .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_sample (out_sample)
    );

    assign m_axis_tdata = TD_W'(out_sample);

endmodule

### tb/tb.sv
// Self-checking testbench for overlap_add_time_stretch: push/pull/drain/restart items
// against an in-bench predictor of the stretcher. Depends on ots_pkg and the RTL top.
module tb;
    import ots_pkg::*;

    localparam int MAXSEG = DEF_MAX_SEGMENT;
    localparam int SBITS  = DEF_SAMPLE_BITS;
    localparam int CYCLE_LIMIT = 30000000;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [SBITS-1:0]  smp;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [SBITS-1:0] s_axis_tdata = '0;
    logic [ACT_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [SBITS-1:0] m_axis_tdata;
    logic [STAT_W-1:0] m_axis_tuser;

    overlap_add_time_stretch DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stretcher state as predicted
    int unsigned seg_reg, ish_reg, osh_reg, fade_reg, step_reg;
    longint in_seg[MAXSEG];
    longint ola_acc[MAXSEG];
    int unsigned fill_pos, emit_pos;
    bit out_phase, draining;

    result_t expected_q[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int combines = 0;
    bit no_idle = 1'b0;
    int hold_request = 0;
    longint unsigned cycles = 0;

    function automatic longint sat(longint v, int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic int unsigned eff_seg();
        return seg_reg < MIN_SEGMENT ? MIN_SEGMENT : (seg_reg > MAXSEG ? MAXSEG : seg_reg);
    endfunction

    function automatic int unsigned clamp_shift(int unsigned v, int unsigned seg);
        return v < 1 ? 1 : (v > seg ? seg : v);
    endfunction

    function automatic int unsigned ramp_coef(int unsigned k, int unsigned fade,
                                              int unsigned step);
        longint w;
        if (k == 0)
            return 65536;
        if (k >= fade - 1)
            return 0;
        w = longint'(step) * longint'(fade - 1 - k);
        return w > 65536 ? 65536 : int'(w);
    endfunction

    function automatic void overlap_add(int unsigned seg);
        int unsigned fade, step, w;
        longint add;
        fade = fade_reg > seg / 2 ? seg / 2 : fade_reg;
        step = step_reg > 65536 ? 65536 : step_reg;
        combines++;
        for (int unsigned i = 0; i < seg; i++)
        begin
            w = 65536;
            if (i < fade)
                w = ramp_coef(fade - 1 - i, fade, step);
            else if (i >= seg - fade)
                w = ramp_coef(i - (seg - fade), fade, step);
            // weighted add rounds half up, floor after the shift
            add = (w == 65536) ? in_seg[i] : ((in_seg[i] * longint'(w) + 32768) >>> 16);
            ola_acc[i] = sat(ola_acc[i] + add, ACC_BITS);
        end
    endfunction

    function automatic void clear_stores(int unsigned half);
        for (int i = 0; i < MAXSEG; i++)
        begin
            in_seg[i] = 0;
            ola_acc[i] = 0;
        end
        fill_pos = half;
        emit_pos = half;
        out_phase = 1'b0;
        draining = 1'b0;
    endfunction

    function automatic result_t stretch_item(logic [ACT_W-1:0] act, logic signed [SBITS-1:0] smp);
        result_t r;
        int unsigned seg, sh;
        longint v;
        seg = eff_seg();
        v = 0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH:
                if (out_phase || draining)
                    r.status = ST_REFUSE;
                else
                begin
                    sh = clamp_shift(ish_reg, seg);
                    if (fill_pos >= seg)
                        fill_pos = seg - 1;
                    in_seg[fill_pos] = longint'(smp);
                    fill_pos++;
                    if (fill_pos == seg)
                    begin
                        overlap_add(seg);
                        for (int unsigned i = 0; i + sh < seg; i++)
                            in_seg[i] = in_seg[i + sh];
                        fill_pos -= sh;
                        out_phase = 1'b1;
                    end
                end
            ACT_PULL:
                if (draining)
                begin
                    if (emit_pos < fill_pos && emit_pos < seg)
                    begin
                        v = sat(ola_acc[emit_pos], SBITS);
                        emit_pos++;
                        r.status = ST_GIVEN;
                    end
                    else
                        r.status = ST_TAIL;
                end
                else if (!out_phase)
                    r.status = ST_REFUSE;
                else
                begin
                    sh = clamp_shift(osh_reg, seg);
                    if (emit_pos < sh)
                    begin
                        v = sat(ola_acc[emit_pos], SBITS);
                        emit_pos++;
                        r.status = ST_GIVEN;
                    end
                    if (emit_pos >= sh)
                    begin
                        int unsigned i;
                        emit_pos -= sh;
                        for (i = 0; i + sh < seg; i++)
                            ola_acc[i] = ola_acc[i + sh];
                        for (; i < seg; i++)
                            ola_acc[i] = 0;
                        out_phase = 1'b0;
                    end
                end
            ACT_DRAIN:
                if (draining)
                    r.status = ST_REFUSE;
                else
                begin
                    if (!out_phase)
                    begin
                        for (int unsigned i = fill_pos; i < seg; i++)
                            in_seg[i] = 0;
                        overlap_add(seg);
                        out_phase = 1'b1;
                    end
                    draining = 1'b1;
                end
            default:
                clear_stores(seg / 2);
        endcase
        r.smp = v[SBITS-1:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SEGMENT_LEN:  seg_reg = value & 32'h7FF;
            REG_INPUT_SHIFT:  ish_reg = value & 32'h7FF;
            REG_OUTPUT_SHIFT: osh_reg = value & 32'h7FF;
            REG_FADE_LEN:     fade_reg = value & 32'h3FF;
            default:          step_reg = value & 32'h1FFFF;
        endcase
    endtask

    task automatic set_all(int unsigned seg, int unsigned ish, int unsigned osh,
                           int unsigned fade, int unsigned step);
        write_reg(REG_SEGMENT_LEN, seg);
        write_reg(REG_INPUT_SHIFT, ish);
        write_reg(REG_OUTPUT_SHIFT, osh);
        write_reg(REG_FADE_LEN, fade);
        write_reg(REG_FADE_STEP, step);
    endtask

    task automatic send_item(logic [ACT_W-1:0] act, logic [SBITS-1:0] smp);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= smp;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_q.push_back(stretch_item(act, smp));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [SBITS-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return SBITS'($urandom());
        endcase
    endfunction

    // mostly well-formed traffic that follows the predicted phase, some noise
    function automatic logic [ACT_W-1:0] pick_action();
        int p;
        p = $urandom_range(999);
        if (draining)
            return (p < 850 || emit_pos < fill_pos) ? ACT_PULL : (p < 950 ? ACT_RESTART : ACT_PUSH);
        if (out_phase)
            return p < 930 ? ACT_PULL : (p < 970 ? ACT_PUSH : ACT_DRAIN);
        return p < 950 ? ACT_PUSH : (p < 980 ? ACT_PULL : (p < 996 ? ACT_DRAIN : ACT_RESTART));
    endfunction

    always @(posedge clk)
    begin
        result_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result status=%0d sample=%0d", m_axis_tuser,
                       $signed(m_axis_tdata));
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_axis_tuser !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== e.smp)
                begin
                    $error("out_sample: expected %0d, got %0d", $signed(e.smp),
                           $signed(m_axis_tdata));
                    errors++;
                end
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        int hold_left;
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && (no_idle || $urandom_range(99) >= 32);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_defaults_and_drain();
        send_item(ACT_PUSH, 16'h7FFF);
        send_item(ACT_PUSH, 16'h8000);
        send_item(ACT_PUSH, 16'h0000);
        send_item(ACT_PULL, 16'h1234);   // wrong phase
        send_item(ACT_DRAIN, 16'h0);
        send_item(ACT_PUSH, 16'h5555);   // refused while draining
        send_item(ACT_DRAIN, 16'h0);     // second drain refused
        repeat (4) send_item(ACT_PULL, 16'h0);
        send_item(ACT_RESTART, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_register_edges();
        // clamped shifts, fade of one, step above unity, fill past the new segment end
        set_all(5, 0, 2047, 1, 17'h1FFFF);
        send_item(ACT_PUSH, 16'h4000);
        send_item(ACT_PUSH, 16'h1);      // output phase, refused
        send_item(ACT_PULL, 16'h0);      // emit already past the window
        send_item(ACT_RESTART, 16'h0);
        wait_idle();
        set_all(8, 3, 3, 4, 21845);
        send_item(ACT_PUSH, 16'h7FFF);
        send_item(ACT_PUSH, 16'h8000);
        send_item(ACT_PUSH, 16'h7FFF);
        send_item(ACT_PUSH, 16'hAAAA);
        send_item(ACT_PUSH, 16'h5555);
        send_item(ACT_PUSH, 16'h8000);
        send_item(ACT_PULL, 16'h0);
        wait_idle();
    endtask

    task automatic test_longest_segment();
        set_all(2047, 2047, 1024, 1023, 128);
        send_item(ACT_RESTART, 16'h0);
        repeat (4) send_item(ACT_PUSH, rand_sample());
        send_item(ACT_DRAIN, 16'h0);
        repeat (6) send_item(ACT_PULL, 16'h0);
        send_item(ACT_RESTART, 16'h0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_all(6, 2, 3, 3, 32768);
        hold_request = 400;
        repeat (40) send_item(pick_action(), rand_sample());
        wait_idle();
    endtask

    task automatic test_random_traffic(int total);
        int unsigned seg, fade;
        int phase_no;
        phase_no = 0;
        while (items_sent < total)
        begin
            case ($urandom_range(99)) inside
                [0:69]:  seg = $urandom_range(32, 4);
                [70:93]: seg = $urandom_range(200, 33);
                [94:96]: seg = $urandom_range(3, 0);
                default: seg = $urandom_range(2047, 900);
            endcase
            fade = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(seg / 2);
            set_all(seg,
                    ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(seg, 0),
                    ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(seg, 0),
                    fade,
                    ($urandom_range(4) == 0) ? $urandom_range(131071)
                                             : (fade > 1 ? 65536 / (fade - 1) : 0));
            no_idle = (phase_no == 3);
            if ($urandom_range(3) == 0)
                send_item(ACT_RESTART, rand_sample());
            repeat (120) send_item(pick_action(), rand_sample());
            wait_idle();
            phase_no++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        seg_reg = SEG_RESET;
        ish_reg = ISH_RESET;
        osh_reg = OSH_RESET;
        fade_reg = FADE_RESET;
        step_reg = STEP_RESET;
        clear_stores(POS_RESET);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_defaults_and_drain();
        test_register_edges();
        test_longest_segment();
        test_backpressure();
        test_random_traffic(1500);
        repeat (50) @(posedge clk);
        $display("Ran %0d items through push, pull, drain and restart; %0d results checked,",
                 items_sent, results_seen);
        $display("%0d overlap-add combines, segment sizes from clamped minimum to maximum.",
                 combines);
        if (errors == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
